>>> design/pwt_pkg.sv
// Shared types, constants and register codes for the pulse-width single-wire transmitter.
`timescale 1ns / 1ps

package pwt_pkg;

    localparam int DUR_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 5;
    localparam int DEF_QUEUE_DEPTH = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_LOW  = 3'd6;

    // Reset values, microseconds
    localparam logic [DUR_W-1:0] RST_SYNC_LOW  = 16'd62000;
    localparam logic [DUR_W-1:0] RST_SYNC_HIGH = 16'd2000;
    localparam logic [DUR_W-1:0] RST_ONE_LOW   = 16'd2000;
    localparam logic [DUR_W-1:0] RST_ONE_HIGH  = 16'd4000;
    localparam logic [DUR_W-1:0] RST_ZERO_LOW  = 16'd4000;
    localparam logic [DUR_W-1:0] RST_ZERO_HIGH = 16'd2000;
    localparam logic [DUR_W-1:0] RST_STOP_LOW  = 16'd1000;
    localparam logic [DUR_W-1:0] RELEASE_DUR   = 16'd0;

    // Segment positions within one transaction's full sequence:
    // sync low, sync high, sixteen bit halves, stop low, release high.
    localparam logic [STEP_W-1:0] SYNC_LOW_STEP  = 5'd0;
    localparam logic [STEP_W-1:0] FIRST_BIT_STEP = 5'd2;
    localparam logic [STEP_W-1:0] LAST_BIT_STEP  = 5'd17;
    localparam logic [STEP_W-1:0] RELEASE_STEP   = 5'd19;

    localparam logic [2:0] MSB_POS = 3'd7;

    typedef struct packed {
        logic [DUR_W-1:0] sync_low;
        logic [DUR_W-1:0] sync_high;
        logic [DUR_W-1:0] one_low;
        logic [DUR_W-1:0] one_high;
        logic [DUR_W-1:0] zero_low;
        logic [DUR_W-1:0] zero_high;
        logic [DUR_W-1:0] stop_low;
    } cfg_t;

    // One classified byte waiting for the back end
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [STEP_W-1:0] first_step;
        logic [STEP_W-1:0] final_step;
    } desc_t;

endpackage

>>> design/pwt_front.sv
// Front end: accepts bytes, classifies them into segment ranges and queues them.
`timescale 1ns / 1ps

module pwt_front
    import pwt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              first_byte,
    input  logic              last_byte,
    output logic              desc_valid,
    output desc_t             desc,
    input  logic              desc_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    desc_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    desc_t            new_desc;
    logic             push;
    logic             pop;

    // Classify: sync only for an opening byte, stop only for a closing byte
    always_comb
    begin
        new_desc.data       = data_byte;
        new_desc.first_step = first_byte ? SYNC_LOW_STEP : FIRST_BIT_STEP;
        new_desc.final_step = last_byte ? RELEASE_STEP : LAST_BIT_STEP;
    end

    assign in_stall   = (count_reg == FULL_CNT);
    assign desc_valid = (count_reg != '0);
    assign desc       = entry_reg[rd_ptr_reg];
    assign push       = in_valid && !in_stall;
    assign pop        = desc_pop && desc_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_desc;
        end
    end

endmodule

>>> design/pwt_back.sv
// Back end: steps a queued byte's segments into an output register, one per cycle unless stalled.
`timescale 1ns / 1ps

module pwt_back
    import pwt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             desc_valid,
    input  desc_t            desc,
    output logic             desc_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             line_level,
    output logic [DUR_W-1:0] duration_us,
    output logic             last_segment
);

    logic              busy_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] final_reg;
    logic              out_valid_reg;
    logic              level_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic              last_reg;

    logic              advance;
    logic              at_final;
    logic              load;
    logic [STEP_W-1:0] bit_off;
    logic [2:0]        bit_idx;
    logic              bit_val;
    logic [DUR_W-1:0]  seg_dur;

    // Output register frees when empty or being taken this cycle
    assign advance  = busy_reg && (!out_valid_reg || !out_stall);
    assign at_final = (step_reg == final_reg);
    assign load     = !busy_reg || (advance && at_final);
    assign desc_pop = load && desc_valid;

    assign bit_off = step_reg - FIRST_BIT_STEP;
    assign bit_idx = bit_off[3:1];
    assign bit_val = byte_reg[MSB_POS - bit_idx];

    // Even steps are low halves, odd steps high halves
    always_comb
    begin
        if (step_reg < FIRST_BIT_STEP)
        begin
            seg_dur = step_reg[0] ? cfg.sync_high : cfg.sync_low;
        end
        else if (step_reg > LAST_BIT_STEP)
        begin
            seg_dur = step_reg[0] ? RELEASE_DUR : cfg.stop_low;
        end
        else if (bit_val)
        begin
            seg_dur = step_reg[0] ? cfg.one_high : cfg.one_low;
        end
        else
        begin
            seg_dur = step_reg[0] ? cfg.zero_high : cfg.zero_low;
        end
    end

    assign step_next = step_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= desc_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_pop)
        begin
            byte_reg  <= desc.data;
            step_reg  <= desc.first_step;
            final_reg <= desc.final_step;
        end
        else if (advance)
        begin
            step_reg <= step_next;
        end
        if (advance)
        begin
            level_reg <= step_reg[0];
            dur_reg   <= seg_dur;
            last_reg  <= at_final;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_level   = level_reg;
    assign duration_us  = dur_reg;
    assign last_segment = last_reg;

endmodule

>>> design/pulse_width_one_wire_transmitter_core.sv
// Top level of the pulse-width coded single-wire serial transmitter.
`timescale 1ns / 1ps

// Each input transaction carries one frame byte with first/last marks and
// yields a run of line segments (level plus hold time in microseconds):
// an optional sync header (low, high) when first_byte is set, sixteen bit
// halves MSB first (low then high, timed by the one or zero registers),
// and an optional stop low plus a release high of duration 0 when
// last_byte is set. last_segment flags the final segment of each byte.
// A byte therefore yields 16 to 20 segments; the back-end sequencer emits one
// segment per cycle into the output register when not stalled: the rate limit.
// A small descriptor queue (QUEUE_DEPTH entries) sits between the front
// end and the sequencer, so new bytes are taken while the previous one is
// still being sent and consecutive bytes go out back to back.
// out_stall holds the output register and freezes the sequencer.
// Timing registers are written through cfg_we/cfg_index/cfg_data, one
// index per register (0 sync low .. 6 stop low); other indexes are ignored.
// Write them only while the block is idle. No clearing pass after reset.

module pulse_width_one_wire_transmitter_core
    import pwt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 first_byte,
    input  logic                 last_byte,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 line_level,
    output logic [DUR_W-1:0]     duration_us,
    output logic                 last_segment
);

    cfg_t  cfg_reg;
    logic  desc_valid;
    desc_t desc;
    logic  desc_pop;

    // Timing registers: load on write enable, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_low  <= RST_SYNC_LOW;
            cfg_reg.sync_high <= RST_SYNC_HIGH;
            cfg_reg.one_low   <= RST_ONE_LOW;
            cfg_reg.one_high  <= RST_ONE_HIGH;
            cfg_reg.zero_low  <= RST_ZERO_LOW;
            cfg_reg.zero_high <= RST_ZERO_HIGH;
            cfg_reg.stop_low  <= RST_STOP_LOW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_LOW:  cfg_reg.sync_low  <= cfg_data;
                REG_SYNC_HIGH: cfg_reg.sync_high <= cfg_data;
                REG_ONE_LOW:   cfg_reg.one_low   <= cfg_data;
                REG_ONE_HIGH:  cfg_reg.one_high  <= cfg_data;
                REG_ZERO_LOW:  cfg_reg.zero_low  <= cfg_data;
                REG_ZERO_HIGH: cfg_reg.zero_high <= cfg_data;
                REG_STOP_LOW:  cfg_reg.stop_low  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Accept and classify bytes, queue them for the sequencer
    pwt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_pop   (desc_pop)
    );

    // Emit segments one per cycle unless out_stall holds them
    pwt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .desc_valid   (desc_valid),
        .desc         (desc),
        .desc_pop     (desc_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_level   (line_level),
        .duration_us  (duration_us),
        .last_segment (last_segment)
    );

endmodule

>>> test/pulse_width_one_wire_transmitter_core_tb.sv
// Self-checking testbench for the pulse-width single-wire transmitter core.
`timescale 1ns / 1ps

module pulse_width_one_wire_transmitter_core_tb;
    import pwt_pkg::*;

    // Index 7 has no register behind it; writes there must leave timing alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_BYTES   = 25;

    // One byte offered on the input channel, with its frame marks
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              opens;
        logic              closes;
    } frame_byte_t;

    // One line segment as the output channel should carry it
    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] dur;
        logic             final_seg;
    } segment_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SYNC_LOW;
    logic [DUR_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 first_byte = 1'b0;
    logic                 last_byte = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 line_level;
    logic [DUR_W-1:0]     duration_us;
    logic                 last_segment;

    // Shadow copy of the timing registers, updated on every write
    cfg_t timing;

    frame_byte_t pending_bytes[$];      // bytes not yet put on the input channel
    frame_byte_t on_bus;                // byte currently offered to the core
    segment_t    expected_segments[$];  // segments predicted but not yet seen

    int  send_gap = 0;       // cycles left in the current sender idle burst
    int  recv_stall = 0;     // cycles left in the current receiver stall burst
    bit  calm = 1'b0;        // no idling in the closing part of the run
    int  failures = 0;
    int  bytes_sent = 0;
    int  segments_checked = 0;
    int  settings_used = 1;
    int  cycles = 0;

    pulse_width_one_wire_transmitter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_level   (line_level),
        .duration_us  (duration_us),
        .last_segment (last_segment)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Encode one byte into its run of line segments under the current timing:
    // optional sync pair, sixteen bit halves MSB first, optional stop and
    // zero-length release. Flag the final segment of the run.
    function automatic void predict_segments(frame_byte_t b);
        segment_t run[$];
        segment_t s;
        begin
            if (b.opens)
            begin
                run.push_back('{level: 1'b0, dur: timing.sync_low, final_seg: 1'b0});
                run.push_back('{level: 1'b1, dur: timing.sync_high, final_seg: 1'b0});
            end
            for (int i = 0; i < BYTE_W; i++)
            begin
                if (b.data[BYTE_W - 1 - i])
                begin
                    run.push_back('{level: 1'b0, dur: timing.one_low, final_seg: 1'b0});
                    run.push_back('{level: 1'b1, dur: timing.one_high, final_seg: 1'b0});
                end
                else
                begin
                    run.push_back('{level: 1'b0, dur: timing.zero_low, final_seg: 1'b0});
                    run.push_back('{level: 1'b1, dur: timing.zero_high, final_seg: 1'b0});
                end
            end
            if (b.closes)
            begin
                run.push_back('{level: 1'b0, dur: timing.stop_low, final_seg: 1'b0});
                run.push_back('{level: 1'b1, dur: RELEASE_DUR, final_seg: 1'b0});
            end
            foreach (run[i])
            begin
                s = run[i];
                s.final_seg = (i == run.size() - 1);
                expected_segments.push_back(s);
            end
        end
    endfunction

    // Driver: advance to the next pending byte once the current transaction
    // is taken, holding the payload steady while the core stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_segments(on_bus);
                bytes_sent++;
                // Start a sender idle burst now and then
                if (!calm && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    on_bus = pending_bytes.pop_front();
                    in_valid   <= 1'b1;
                    data_byte  <= on_bus.data;
                    first_byte <= on_bus.opens;
                    last_byte  <= on_bus.closes;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken segment with the oldest prediction, and
    // drive out_stall in random bursts.
    always @(posedge clk)
    begin
        segment_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_segments.size() == 0)
                begin
                    $error("unexpected segment: level %0d duration %0d last %0d",
                           line_level, duration_us, last_segment);
                    failures++;
                end
                else
                begin
                    want = expected_segments.pop_front();
                    segments_checked++;
                    if (line_level !== want.level)
                    begin
                        $error("line_level mismatch: expected %0d, got %0d",
                               want.level, line_level);
                        failures++;
                    end
                    if (duration_us !== want.dur)
                    begin
                        $error("duration_us mismatch: expected %0d, got %0d",
                               want.dur, duration_us);
                        failures++;
                    end
                    if (last_segment !== want.final_seg)
                    begin
                        $error("last_segment mismatch: expected %0d, got %0d",
                               want.final_seg, last_segment);
                        failures++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(0, 16);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: drop the run if the core hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d segments still expected",
                     cycles, expected_segments.size());
            $display("pulse_width_one_wire_transmitter_core verification failed");
            $finish;
        end
    end

    task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic opens,
                              input logic closes);
        pending_bytes.push_back('{data: data, opens: opens, closes: closes});
    endtask

    // Wait until every byte is taken and every segment seen, then let the
    // sequencer settle before anything touches the registers.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_segments.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register write; the core latches it at the edge where cfg_we is high
    task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SYNC_LOW:  timing.sync_low  = value;
            REG_SYNC_HIGH: timing.sync_high = value;
            REG_ONE_LOW:   timing.one_low   = value;
            REG_ONE_HIGH:  timing.one_high  = value;
            REG_ZERO_LOW:  timing.zero_low  = value;
            REG_ZERO_HIGH: timing.zero_high = value;
            REG_STOP_LOW:  timing.stop_low  = value;
            default:       ;
        endcase
    endtask

    task automatic program_timing(input cfg_t t);
        write_timing(REG_SYNC_LOW,  t.sync_low);
        write_timing(REG_SYNC_HIGH, t.sync_high);
        write_timing(REG_ONE_LOW,   t.one_low);
        write_timing(REG_ONE_HIGH,  t.one_high);
        write_timing(REG_ZERO_LOW,  t.zero_low);
        write_timing(REG_ZERO_HIGH, t.zero_high);
        write_timing(REG_STOP_LOW,  t.stop_low);
        settings_used++;
    endtask

    // Mostly well-formed frames of 1 to 5 bytes with random content; the
    // rest are loose bytes with random marks (unopened, unclosed, both).
    task automatic queue_random_traffic(input int count);
        int queued;
        int frame_len;
        queued = 0;
        while (queued < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                queue_byte(BYTE_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                queued++;
            end
            else
            begin
                frame_len = $urandom_range(1, 5);
                for (int k = 0; k < frame_len; k++)
                    queue_byte(BYTE_W'($urandom_range(0, 255)), k == 0, k == frame_len - 1);
                queued += frame_len;
            end
        end
    endtask

    // Stimulus: reset, directed bytes at reset timing, then the timing
    // extremes, then random timing settings with random traffic.
    initial
    begin
        cfg_t t;
        timing = '{sync_low: RST_SYNC_LOW, sync_high: RST_SYNC_HIGH,
                   one_low: RST_ONE_LOW, one_high: RST_ONE_HIGH,
                   zero_low: RST_ZERO_LOW, zero_high: RST_ZERO_HIGH,
                   stop_low: RST_STOP_LOW};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset timing: a three-byte frame, single-byte frames with both
        // marks, unmarked bytes, a close without an open, a reopen mid-frame
        queue_byte(8'hA5, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(8'h80, 1'b1, 1'b1);
        queue_byte(8'h01, 1'b1, 1'b1);
        queue_byte(8'h55, 1'b0, 1'b0);
        queue_byte(8'hAA, 1'b0, 1'b0);
        queue_byte(8'h7F, 1'b0, 1'b1);
        queue_byte(8'hFE, 1'b1, 1'b0);
        queue_byte(8'h3C, 1'b1, 1'b0);
        queue_byte(8'hC3, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b1, 1'b1);
        queue_byte(8'hFF, 1'b1, 1'b1);
        wait_idle();

        // All timings zero: every segment carries duration 0
        program_timing('0);
        queue_byte(8'h00, 1'b1, 1'b1);
        queue_byte(8'hFF, 1'b1, 1'b1);
        queue_byte(8'h5A, 1'b0, 1'b0);
        wait_idle();

        // All timings at full scale; the unused index must be ignored
        program_timing('1);
        write_timing(REG_UNUSED, 16'h0000);
        queue_byte(8'hFF, 1'b1, 1'b1);
        queue_byte(8'h00, 1'b1, 1'b1);
        queue_byte(8'h96, 1'b0, 1'b0);
        wait_idle();

        // Random timing per phase; drop idling in the last one
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            t.sync_low  = DUR_W'($urandom_range(0, 65535));
            t.sync_high = DUR_W'($urandom_range(0, 65535));
            t.one_low   = DUR_W'($urandom_range(0, 65535));
            t.one_high  = DUR_W'($urandom_range(0, 65535));
            t.zero_low  = DUR_W'($urandom_range(0, 65535));
            t.zero_high = DUR_W'($urandom_range(0, 65535));
            t.stop_low  = DUR_W'($urandom_range(0, 65535));
            program_timing(t);
            write_timing(REG_UNUSED, DUR_W'($urandom_range(0, 65535)));
            if (p == RANDOM_PHASES - 1)
                calm = 1'b1;
            queue_random_traffic(PHASE_BYTES);
            wait_idle();
        end

        $display("sent %0d bytes under %0d timing settings, checked %0d line segments",
                 bytes_sent, settings_used, segments_checked);
        $display("covered sync, bit, stop and release segments with idle and stall bursts");
        if (failures == 0)
            $display("pulse_width_one_wire_transmitter_core verification clean");
        else
            $display("pulse_width_one_wire_transmitter_core verification failed");
        $finish;
    end

endmodule
